/* src/iougmc_pkg.sv */
// shared constants for the iou gated match cost block
// field widths, register indexes and reset values; no dependencies
package iougmc_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int FRAC_BITS_DEF  = 16;

	localparam int FRAMES_W   = 8;
	localparam int STALE_W    = 8;
	localparam int COST_W     = 20;
	localparam int M_DATA_W   = ((COST_W + 7) / 8) * 8;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = COST_W;

	localparam logic [CFG_INDEX_W-1:0] REG_STALE_LIMIT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GATE_COST   = 2'd1;

	localparam logic [STALE_W-1:0] STALE_LIMIT_RST = 8'd1;
	localparam logic [COST_W-1:0]  GATE_COST_RST   = 20'hFFFFF;

endpackage

/* src/iou_gated_match_cost_top.sv */
// iou match cost pipeline: overlap, areas, union and a restoring divider
// depends on iougmc_pkg
//
// usage
//   s_tdata carries one track/detection box pair per request, m_tdata returns
//   the cost (1 - iou) as an unsigned fraction with FRAC_BITS bits; m_tuser
//   flags a stale track that got the programmed gate cost instead
//   cfg_valid/cfg_ready writes stale_limit (index 0) or gate_cost (index 1);
//   cfg_ready is always high and other indexes are dropped; write only while idle
// throughput: one request per cycle, sustained, set by the fully pipelined
//   divider that resolves one quotient bit per stage
// latency: FRAC_BITS + 6 cycles from the accepting edge to m_tvalid
//   (FRAC_BITS + 7 register stages, the first loaded at the accepting edge:
//   overlap, multiply, area sum, union/difference, FRAC_BITS + 2 divider
//   stages, output register)
// reset: arst_n clears every valid bit and loads the register defaults
//   (stale_limit 1, gate_cost all ones); no clearing pass
// stall: each stage holds while the one after it is full and blocked, so
//   empty stages still fill and s_tready only falls once the pipe is full
module iou_gated_match_cost_top #(
	parameter int COORD_BITS = iougmc_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = iougmc_pkg::FRAC_BITS_DEF,
	localparam int S_DATA_W  = ((8 * COORD_BITS + iougmc_pkg::FRAMES_W + 7) / 8) * 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input request channel
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// low to high: track_left, track_top, track_wide, track_tall, det_left,
	// det_top, det_wide, det_tall (COORD_BITS each), frames_unmatched (8), zero pad
	input  logic [S_DATA_W-1:0]                  s_tdata,
	// result channel
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// low to high: match_cost (20), zero pad
	output logic [iougmc_pkg::M_DATA_W-1:0]      m_tdata,
	// bit 0: was_gated
	output logic [0:0]                           m_tuser,
	// register write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [iougmc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [iougmc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int C  = COORD_BITS;
	localparam int EW = COORD_BITS + 1;       // box end coordinate
	localparam int AW = 2 * COORD_BITS;       // one area
	localparam int UW = 2 * COORD_BITS + 1;   // union, area sum, remainder
	localparam int QW = FRAC_BITS + 2;        // quotient with one extra rounding bit
	localparam int CW = iougmc_pkg::COST_W;

	// ---------------------------------------------------------------
	// configuration registers
	// ---------------------------------------------------------------
	logic [iougmc_pkg::STALE_W-1:0] stale_limit_q;
	logic [CW-1:0]                  gate_cost_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stale_limit_q <= iougmc_pkg::STALE_LIMIT_RST;
			gate_cost_q   <= iougmc_pkg::GATE_COST_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				iougmc_pkg::REG_STALE_LIMIT: begin
					stale_limit_q <= cfg_data[iougmc_pkg::STALE_W-1:0];
				end
				iougmc_pkg::REG_GATE_COST: begin
					gate_cost_q <= cfg_data[CW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// ---------------------------------------------------------------
	// request unpacking
	// ---------------------------------------------------------------
	logic [C-1:0] tl, tt, tw, th, dl, dt, dw, dh;
	logic [iougmc_pkg::FRAMES_W-1:0] frames;

	assign tl     = s_tdata[0*C +: C];
	assign tt     = s_tdata[1*C +: C];
	assign tw     = s_tdata[2*C +: C];
	assign th     = s_tdata[3*C +: C];
	assign dl     = s_tdata[4*C +: C];
	assign dt     = s_tdata[5*C +: C];
	assign dw     = s_tdata[6*C +: C];
	assign dh     = s_tdata[7*C +: C];
	assign frames = s_tdata[8*C +: iougmc_pkg::FRAMES_W];

	// ---------------------------------------------------------------
	// per-stage load enables: a stage loads when it is empty or its
	// content moves on, so bubbles collapse under a stalled output
	// ---------------------------------------------------------------
	logic          v_s1, v_s2, v_s3, v_s4;
	logic          en_s1, en_s2, en_s3, en_s4, en_out;
	logic [QW-1:0] dv_s;
	logic [QW-1:0] en_d;

	assign en_out = !m_tvalid || m_tready;
	assign en_s4  = !v_s4 || en_d[0];
	assign en_s3  = !v_s3 || en_s4;
	assign en_s2  = !v_s2 || en_s3;
	assign en_s1  = !v_s1 || en_s2;
	assign s_tready = en_s1;

	// ---------------------------------------------------------------
	// stage 1: overlap on each axis, clipped at zero; stale gate compare
	// ---------------------------------------------------------------
	logic [EW-1:0] tx_end, dx_end, ty_end, dy_end;
	logic [EW-1:0] x_lo, x_hi, y_lo, y_hi;
	logic [C-1:0]  ox, oy;
	logic [EW-1:0] x_len, y_len;

	always_comb begin
		tx_end = {1'b0, tl} + {1'b0, tw};
		dx_end = {1'b0, dl} + {1'b0, dw};
		ty_end = {1'b0, tt} + {1'b0, th};
		dy_end = {1'b0, dt} + {1'b0, dh};
		x_lo   = (tl > dl) ? {1'b0, tl} : {1'b0, dl};
		y_lo   = (tt > dt) ? {1'b0, tt} : {1'b0, dt};
		x_hi   = (tx_end < dx_end) ? tx_end : dx_end;
		y_hi   = (ty_end < dy_end) ? ty_end : dy_end;
		x_len  = x_hi - x_lo;
		y_len  = y_hi - y_lo;
		// an overlap never exceeds either width, so it fits the coordinate width
		ox     = (x_hi > x_lo) ? x_len[C-1:0] : '0;
		oy     = (y_hi > y_lo) ? y_len[C-1:0] : '0;
	end

	logic [C-1:0] ox_s1, oy_s1, tw_s1, th_s1, dw_s1, dh_s1;
	logic         gated_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && s_tvalid) begin
			ox_s1    <= ox;
			oy_s1    <= oy;
			tw_s1    <= tw;
			th_s1    <= th;
			dw_s1    <= dw;
			dh_s1    <= dh;
			gated_s1 <= frames > stale_limit_q;
		end
	end

	// ---------------------------------------------------------------
	// stage 2: intersection and box areas, three parallel multipliers
	// ---------------------------------------------------------------
	logic [AW-1:0] inter_s2, tarea_s2, darea_s2;
	logic          gated_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			inter_s2 <= AW'(ox_s1) * AW'(oy_s1);
			tarea_s2 <= AW'(tw_s1) * AW'(th_s1);
			darea_s2 <= AW'(dw_s1) * AW'(dh_s1);
			gated_s2 <= gated_s1;
		end
	end

	// ---------------------------------------------------------------
	// stage 3: sum of the two box areas
	// ---------------------------------------------------------------
	logic [UW-1:0] sum_s3;
	logic [UW-1:0] inter_s3;
	logic          gated_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			sum_s3   <= {1'b0, tarea_s2} + {1'b0, darea_s2};
			inter_s3 <= {1'b0, inter_s2};
			gated_s3 <= gated_s2;
		end
	end

	// ---------------------------------------------------------------
	// stage 4: union = sum - inter, dividend = union - inter
	// the union is zero exactly when both boxes have zero area
	// ---------------------------------------------------------------
	logic [UW-1:0] uni_s4, diff_s4;
	logic          gated_s4, uzero_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			uni_s4   <= sum_s3 - inter_s3;
			diff_s4  <= sum_s3 - {inter_s3[UW-2:0], 1'b0};
			gated_s4 <= gated_s3;
			uzero_s4 <= sum_s3 == '0;
		end
	end

	// ---------------------------------------------------------------
	// divider: q2 = floor(diff * 2^(FRAC_BITS+1) / uni), one bit per stage,
	// msb first; diff <= uni so the top bit needs no shift
	// ---------------------------------------------------------------
	logic [UW-1:0] dr_s [QW];
	logic [UW-1:0] du_s [QW];
	logic [QW-1:0] dq_s [QW];
	logic [QW-1:0] dg_s;
	logic [QW-1:0] dz_s;

	for (genvar k = 0; k < QW; k++) begin : g_div
		logic [UW:0]   trial;
		logic [UW:0]   trial_sub;
		logic          qbit;
		logic [UW-1:0] div_in;
		logic [QW-1:0] q_in;
		logic          v_in, g_in, z_in;

		if (k == QW - 1) begin : g_en_last
			assign en_d[k] = !dv_s[k] || en_out;
		end else begin : g_en_mid
			assign en_d[k] = !dv_s[k] || en_d[k+1];
		end

		if (k == 0) begin : g_first
			assign trial  = {1'b0, diff_s4};
			assign div_in = uni_s4;
			assign q_in   = '0;
			assign v_in   = v_s4;
			assign g_in   = gated_s4;
			assign z_in   = uzero_s4;
		end else begin : g_next
			assign trial  = {dr_s[k-1], 1'b0};
			assign div_in = du_s[k-1];
			assign q_in   = dq_s[k-1];
			assign v_in   = dv_s[k-1];
			assign g_in   = dg_s[k-1];
			assign z_in   = dz_s[k-1];
		end

		assign trial_sub = trial - {1'b0, div_in};
		assign qbit      = trial >= {1'b0, div_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[k] <= 1'b0;
			end else if (en_d[k]) begin
				dv_s[k] <= v_in;
			end
		end

		// after the subtract the remainder is below the divisor
		always_ff @(posedge clk) begin
			if (en_d[k] && v_in) begin
				dr_s[k] <= qbit ? trial_sub[UW-1:0] : trial[UW-1:0];
				du_s[k] <= div_in;
				dq_s[k] <= {q_in[QW-2:0], qbit};
				dg_s[k] <= g_in;
				dz_s[k] <= z_in;
			end
		end
	end

	// ---------------------------------------------------------------
	// output register: round half up by (q2 + 1) >> 1, then the
	// zero-union and gated overrides
	// ---------------------------------------------------------------
	logic [QW-1:0] q_round;
	logic [CW-1:0] cost_ratio;
	logic [CW-1:0] cost_next;

	always_comb begin
		q_round    = dq_s[QW-1] + QW'(1);
		cost_ratio = CW'(q_round[QW-1:1]);
		if (dg_s[QW-1]) begin
			cost_next = gate_cost_q;
		end else if (dz_s[QW-1]) begin
			cost_next = CW'(1) << FRAC_BITS;
		end else begin
			cost_next = cost_ratio;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en_out) begin
			m_tvalid <= dv_s[QW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && dv_s[QW-1]) begin
			m_tdata <= iougmc_pkg::M_DATA_W'(cost_next);
			m_tuser <= dg_s[QW-1];
		end
	end

endmodule

/* src/iougmc_checker.sv */
// port-level checks for the iou gated match cost block, bound to the top level
// depends on iougmc_pkg and iou_gated_match_cost_top
module iougmc_checker #(
	parameter int FRAC_BITS = iougmc_pkg::FRAC_BITS_DEF
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [iougmc_pkg::M_DATA_W-1:0] m_tdata,
	input logic [0:0]                      m_tuser
);

	localparam int CAP   = FRAC_BITS + 7;
	localparam int CNT_W = $clog2(CAP + 1) + 1;
	localparam int CW    = iougmc_pkg::COST_W;

	logic [CNT_W-1:0] pending_q;
	logic             in_acc, out_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + CNT_W'(1);
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - CNT_W'(1);
		end
	end

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// every result belongs to an earlier request
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pending_q != '0)
		else $error("result without a pending request");

	// the pipe never holds more requests than it has stages
	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= CNT_W'(CAP))
		else $error("more requests in flight than pipeline stages");

	// an ungated cost never exceeds one
	a_cost_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[CW-1:0] <= (CW'(1) << FRAC_BITS))
		else $error("iou cost above one");

endmodule

bind iou_gated_match_cost_top iougmc_checker #(
	.FRAC_BITS(FRAC_BITS)
) u_iougmc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

/* verif/tb_top.sv */
// self-checking testbench for iou_gated_match_cost_top: box pairs in, 1 - iou cost out
// predicts each cost from the register shadows; depends on iougmc_pkg and the rtl top
`timescale 1ns / 1ps

module tb_top;
	import iougmc_pkg::*;

	localparam int CB      = COORD_BITS_DEF;
	localparam int FB      = FRAC_BITS_DEF;
	localparam int S_W     = ((8 * CB + FRAMES_W + 7) / 8) * 8;
	localparam int LATENCY = FB + 7;
	localparam int DRAIN_LIMIT = 20000;
	localparam logic [COST_W-1:0] COST_ONE = COST_W'(1) << FB;
	localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};
	// indexes past the register list, writes to them must be dropped
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_2 = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_3 = 2'd3;

	typedef struct {
		logic [CB-1:0]       track_left;
		logic [CB-1:0]       track_top;
		logic [CB-1:0]       track_wide;
		logic [CB-1:0]       track_tall;
		logic [CB-1:0]       det_left;
		logic [CB-1:0]       det_top;
		logic [CB-1:0]       det_wide;
		logic [CB-1:0]       det_tall;
		logic [FRAMES_W-1:0] frames;
	} box_pair_t;

	typedef struct {
		logic [COST_W-1:0] cost;
		logic              gated;
	} match_cost_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [S_W-1:0]         s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [M_DATA_W-1:0]    m_tdata;
	logic [0:0]             m_tuser;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// register shadows, loaded with the reset values
	logic [STALE_W-1:0] stale_lim = STALE_LIMIT_RST;
	logic [COST_W-1:0]  gate_val  = GATE_COST_RST;

	match_cost_t cost_expect_q[$];

	int idle_pct = 38;      // percent of cycles each side idles
	int hold_req = 0;       // receiver hold-off length, picked up by the ready process
	int mismatches = 0;
	int pairs_sent = 0;
	int gated_seen = 0;
	int full_cost_seen = 0;
	int reg_writes = 0;
	int input_stalls = 0;

	iou_gated_match_cost_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #2 clk = ~clk;

	// overlap of [a0, a0+al) and [b0, b0+bl), clipped at zero
	function automatic longint unsigned span_overlap(logic [CB-1:0] a0, logic [CB-1:0] al,
			logic [CB-1:0] b0, logic [CB-1:0] bl);
		longint unsigned lo, hi;
		lo = (a0 > b0) ? 64'(a0) : 64'(b0);
		hi = ((64'(a0) + 64'(al)) < (64'(b0) + 64'(bl))) ?
			(64'(a0) + 64'(al)) : (64'(b0) + 64'(bl));
		return (hi > lo) ? hi - lo : 64'(0);
	endfunction

	// cost of one pair under the current register shadows
	function automatic match_cost_t predict_match_cost(box_pair_t p);
		match_cost_t     r;
		longint unsigned inter, uni, area_t, area_d;
		if (p.frames > stale_lim) begin
			r.cost  = gate_val;
			r.gated = 1'b1;
			return r;
		end
		inter  = span_overlap(p.track_left, p.track_wide, p.det_left, p.det_wide) *
			span_overlap(p.track_top, p.track_tall, p.det_top, p.det_tall);
		area_t = 64'(p.track_wide) * 64'(p.track_tall);
		area_d = 64'(p.det_wide) * 64'(p.det_tall);
		uni    = area_t + area_d - inter;
		r.gated = 1'b0;
		// zero union means cost one rather than a divide by zero
		if (uni == 0)
			r.cost = COST_ONE;
		else
			r.cost = COST_W'((((uni - inter) << FB) + (uni >> 1)) / uni);
		return r;
	endfunction

	function automatic logic [S_W-1:0] pack_pair(box_pair_t p);
		logic [S_W-1:0] v;
		v = '0;
		v[8*CB+FRAMES_W-1:0] = {p.frames, p.det_tall, p.det_wide, p.det_top, p.det_left,
			p.track_tall, p.track_wide, p.track_top, p.track_left};
		return v;
	endfunction

	function automatic box_pair_t make_pair(int tl, int tt, int tw, int th,
			int dl, int dt, int dw, int dh, int fr);
		box_pair_t p;
		p.track_left = CB'(tl);
		p.track_top  = CB'(tt);
		p.track_wide = CB'(tw);
		p.track_tall = CB'(th);
		p.det_left   = CB'(dl);
		p.det_top    = CB'(dt);
		p.det_wide   = CB'(dw);
		p.det_tall   = CB'(dh);
		p.frames     = FRAMES_W'(fr);
		return p;
	endfunction

	// mostly overlapping boxes, where the divider does real work, plus noise
	function automatic box_pair_t rand_pair();
		int        kind, fsel, tl, tt, tw, th, fr;
		box_pair_t p;
		kind = $urandom_range(99);
		tl = $urandom_range(4095);
		tt = $urandom_range(4095);
		tw = $urandom_range(1, 300);
		th = $urandom_range(1, 300);
		if (kind < 55) begin
			p = make_pair(tl, tt, tw, th,
				tl + $urandom_range(2 * tw) - tw, tt + $urandom_range(2 * th) - th,
				tw + $urandom_range(40) - 20, th + $urandom_range(40) - 20, 0);
		end else if (kind < 75) begin
			p = make_pair($urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom, 0);
		end else if (kind < 85) begin
			// tiny boxes, zero sizes included
			p = make_pair(tl, tt, $urandom_range(15), $urandom_range(15),
				tl + $urandom_range(15) - 7, tt + $urandom_range(15) - 7,
				$urandom_range(15), $urandom_range(15), 0);
		end else if (kind < 95) begin
			p = make_pair($urandom_range(200), $urandom_range(200),
				$urandom_range(3000, 4095), $urandom_range(3000, 4095),
				$urandom_range(400), $urandom_range(400),
				$urandom_range(2000, 4095), $urandom_range(2000, 4095), 0);
		end else begin
			// one or both boxes without area
			p = make_pair(tl, tt, $urandom_range(1) * tw, 0,
				tl, tt, $urandom_range(1) ? 0 : tw, $urandom_range(1) ? 0 : th, 0);
		end
		// frame counts cluster around the stale limit
		fsel = $urandom_range(99);
		if (fsel < 55)
			fr = $urandom_range(stale_lim);
		else if (fsel < 80)
			fr = $urandom_range(255);
		else if (fsel < 90)
			fr = int'(stale_lim);
		else
			fr = int'(stale_lim) + 1;
		p.frames = FRAMES_W'(fr);
		return p;
	endfunction

	// offer one pair, with a random idle gap first; tvalid stays high afterwards
	task automatic send_pair(box_pair_t p);
		int          gap;
		match_cost_t r;
		gap = 0;
		while ($urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pack_pair(p);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		r = predict_match_cost(p);
		cost_expect_q.insert(cost_expect_q.size(), r);
		pairs_sent++;
		if (r.gated)
			gated_seen++;
		else if (r.cost == COST_ONE)
			full_cost_seen++;
	endtask

	// stop offering and wait for every pending cost, bounded
	task automatic drain_costs();
		int waited;
		waited = 0;
		s_tvalid <= 1'b0;
		while (cost_expect_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (cost_expect_q.size() != 0) begin
			$display("%0t: %0d costs never arrived", $realtime, cost_expect_q.size());
			mismatches += cost_expect_q.size();
			cost_expect_q.delete();
		end
	endtask

	// one register write request; only called with the pipe empty
	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_STALE_LIMIT: stale_lim = val[STALE_W-1:0];
			REG_GATE_COST:   gate_val  = val[COST_W-1:0];
			default: ;
		endcase
		reg_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// receiver: random tready, or a counted hold-off when one is asked for
	always @(posedge clk) begin
		static int hold_left = 0;
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= ($urandom_range(99) >= idle_pct);
		end
	end

	// result checker: every accepted cost against the oldest prediction
	always @(posedge clk) begin
		match_cost_t want;
		if (s_tvalid && !s_tready)
			input_stalls++;
		if (m_tvalid && m_tready) begin
			if (cost_expect_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected cost %0d gated %0b", $realtime,
						m_tdata[COST_W-1:0], m_tuser[0]);
			end else begin
				want = cost_expect_q.pop_front();
				if (m_tdata[COST_W-1:0] !== want.cost || m_tuser[0] !== want.gated) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: cost mismatch: expected %0d gated %0b, got %0d gated %0b",
							$realtime, want.cost, want.gated, m_tdata[COST_W-1:0], m_tuser[0]);
				end
			end
		end
	end

	// geometry corners under the reset register values
	task automatic test_reset_geometry();
		send_pair(make_pair(100, 100, 50, 50, 100, 100, 50, 50, 0));     // identical, cost zero
		send_pair(make_pair(0, 0, 10, 10, 500, 500, 10, 10, 0));         // disjoint
		send_pair(make_pair(0, 0, 10, 10, 10, 0, 10, 10, 1));            // touching edges
		send_pair(make_pair(0, 0, 10, 10, 0, 10, 10, 10, 0));
		send_pair(make_pair(7, 9, 0, 0, 3, 3, 0, 0, 0));                 // zero union
		send_pair(make_pair(5, 5, 0, 0, 0, 0, 10, 10, 0));               // empty box inside
		send_pair(make_pair(0, 0, 100, 100, 25, 25, 50, 50, 0));         // contained
		send_pair(make_pair(0, 0, 512, 256, 0, 0, 1, 1, 0));             // exact half, rounds up
		send_pair(make_pair(0, 0, 512, 256, 0, 0, 3, 3, 0));
		send_pair(make_pair(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 0));
		send_pair(make_pair(0, 0, 4095, 4095, 4095, 0, 4095, 4095, 0));
		send_pair(make_pair(0, 0, 4095, 4095, 1, 1, 4094, 4094, 1));
		send_pair(make_pair(10, 10, 20, 20, 15, 15, 20, 20, 2));         // stale, gated
		send_pair(make_pair(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 255));
		drain_costs();
	endtask

	// every register, the unused indexes and the extremes of both values
	task automatic test_register_extremes();
		write_reg(REG_UNUSED_2, COST_MAX);
		write_reg(REG_UNUSED_3, '0);
		write_reg(REG_STALE_LIMIT, '0);
		write_reg(REG_GATE_COST, '0);
		send_pair(make_pair(0, 0, 30, 30, 10, 10, 30, 30, 0));
		send_pair(make_pair(0, 0, 30, 30, 10, 10, 30, 30, 1));
		drain_costs();
		write_reg(REG_STALE_LIMIT, 20'hFF);
		write_reg(REG_GATE_COST, COST_MAX);
		send_pair(make_pair(0, 0, 30, 30, 10, 10, 30, 30, 255));
		send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 254));
		drain_costs();
		write_reg(REG_STALE_LIMIT, 20'h5A);
		write_reg(REG_GATE_COST, 20'hA5A5A);
		send_pair(make_pair(0, 0, 30, 30, 10, 10, 30, 30, 8'h5A));
		send_pair(make_pair(0, 0, 30, 30, 10, 10, 30, 30, 8'h5B));
		drain_costs();
		write_reg(REG_STALE_LIMIT, 20'hA5);
		write_reg(REG_GATE_COST, 20'h5A5A5);
		send_pair(make_pair(0, 0, 30, 30, 10, 10, 30, 30, 8'hA6));
		drain_costs();
		write_reg(REG_UNUSED_3, 20'h12345);   // must leave gate_cost alone
		send_pair(make_pair(0, 0, 30, 30, 10, 10, 30, 30, 8'hFF));
		drain_costs();
	endtask

	// random phases, each with its own register values; the pipe empties between them
	task automatic test_random_phases();
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_STALE_LIMIT, CFG_DATA_W'($urandom_range(255)));
			write_reg(REG_GATE_COST, CFG_DATA_W'($urandom_range(20'hFFFFF)));
			// one phase runs without any idling on either side
			idle_pct = (ph == 2) ? 0 : 38;
			for (int n = 0; n < 225; n++)
				send_pair(rand_pair());
			drain_costs();
		end
		idle_pct = 38;
	endtask

	// receiver holds off well past the pipe depth while the sender keeps going
	task automatic test_output_hold();
		write_reg(REG_STALE_LIMIT, 20'd40);
		write_reg(REG_GATE_COST, 20'h00F0F);
		idle_pct = 0;
		hold_req = 4 * LATENCY + 60;
		for (int n = 0; n < 80; n++)
			send_pair(rand_pair());
		idle_pct = 38;
		drain_costs();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_geometry();
		test_register_extremes();
		test_output_hold();
		test_random_phases();
		drain_costs();
		// any stray result in this window is flagged by the checker
		repeat (2 * LATENCY) @(posedge clk);
		$display("covered %0d box pairs (%0d gated, %0d at full cost) over %0d register writes",
			pairs_sent, gated_seen, full_cost_seen, reg_writes);
		$display("input stalled for %0d cycles, %0d mismatches", input_stalls, mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// run limit, far above the slowest legal run
	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

endmodule
